// ===== rtl/mm_pkg.sv =====
// shared constants for the shift-and-add modular multiplier
package mm_pkg;

  // fixed widths of the transaction fields
  localparam int unsigned IN_WIDTH  = 32;
  localparam int unsigned OUT_WIDTH = 31;

endpackage

// ===== rtl/modular_multiplier.sv =====
// top level: iterative shift-and-add modular multiplier
// busy from the accepting edge until the last multiplier step; the result strobe
//   comes in the first idle cycle, as busy falls. A new transaction is taken only
//   when idle, as the single shared step unit serves both phases: first it reduces
//   the multiplicand bit by bit, then it scans the multiplier.
// the receiver cannot stall; each result is shown for exactly one cycle.
// reset (rst_ni low, asynchronous) returns the sequencer to idle, no strobe.
module modular_multiplier #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [mm_pkg::IN_WIDTH-1:0]    multiplier_i,
  input  logic [mm_pkg::IN_WIDTH-1:0]    multiplicand_i,
  input  logic [mm_pkg::IN_WIDTH-1:0]    modulus_i,
  output logic                           done_o,
  output logic [mm_pkg::OUT_WIDTH-1:0]   product_mod_o
);

  localparam int unsigned CntWidth = $clog2(DATA_WIDTH);
  localparam int unsigned InW      = mm_pkg::IN_WIDTH;
  localparam int unsigned OutW     = mm_pkg::OUT_WIDTH;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MULT
  } state_e;

  state_e                state_q;
  logic [CntWidth-1:0]   cnt_q;
  logic                  done_q;

  logic [DATA_WIDTH-1:0] mod_q;
  logic [DATA_WIDTH-1:0] mcand_q;
  logic [DATA_WIDTH-1:0] mplier_q;
  logic [DATA_WIDTH-1:0] rem_q;
  logic [DATA_WIDTH-1:0] acc_q;
  logic                  mod_zero_q;
  logic [OutW-1:0]       result_q;

  logic                  accept;
  logic                  last_step;
  logic [InW+DATA_WIDTH-1:0]  mplier_ext;
  logic [InW+DATA_WIDTH-1:0]  mcand_ext;
  logic [InW+DATA_WIDTH-1:0]  mod_ext;
  logic [OutW+DATA_WIDTH-1:0] acc_ext;

  logic                  shift_bit;
  logic                  add_en;
  logic [DATA_WIDTH-1:0] dbl;
  logic [DATA_WIDTH-1:0] acc_next;

  assign accept    = start_i && (state_q == ST_IDLE);
  assign last_step = (cnt_q == '0);

  // fit the input fields to the datapath width (zero-extend or keep low bits)
  assign mplier_ext = {{DATA_WIDTH{1'b0}}, multiplier_i};
  assign mcand_ext  = {{DATA_WIDTH{1'b0}}, multiplicand_i};
  assign mod_ext    = {{DATA_WIDTH{1'b0}}, modulus_i};
  assign acc_ext    = {{OutW{1'b0}}, acc_next};

  // step unit controls: reduction feeds multiplicand bits msb first
  assign shift_bit = (state_q == ST_REDUCE) ? mcand_q[DATA_WIDTH-1] : 1'b0;
  assign add_en    = (state_q == ST_MULT) && mplier_q[0];

  mm_step_unit #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_step (
    .y_i         (rem_q),
    .shift_bit_i (shift_bit),
    .acc_i       (acc_q),
    .add_en_i    (add_en),
    .modulus_i   (mod_q),
    .dbl_o       (dbl),
    .acc_o       (acc_next)
  );

  // sequencer state and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            state_q <= ST_REDUCE;
            cnt_q   <= CntWidth'(DATA_WIDTH - 1);
          end
        end
        ST_REDUCE: begin
          if (last_step) begin
            state_q <= ST_MULT;
            cnt_q   <= CntWidth'(DATA_WIDTH - 1);
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        ST_MULT: begin
          if (last_step) begin
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mod_q      <= mod_ext[DATA_WIDTH-1:0];
      mcand_q    <= mcand_ext[DATA_WIDTH-1:0];
      mplier_q   <= mplier_ext[DATA_WIDTH-1:0];
      rem_q      <= '0;
      acc_q      <= '0;
      mod_zero_q <= (mod_ext[DATA_WIDTH-1:0] == '0);
    end else if (state_q == ST_REDUCE) begin
      // remainder of the multiplicand, one bit per cycle
      rem_q   <= dbl;
      mcand_q <= {mcand_q[DATA_WIDTH-2:0], 1'b0};
    end else if (state_q == ST_MULT) begin
      // accumulate on set multiplier bits, double the reduced multiplicand
      acc_q    <= acc_next;
      rem_q    <= dbl;
      mplier_q <= {1'b0, mplier_q[DATA_WIDTH-1:1]};
      if (last_step) begin
        result_q <= mod_zero_q ? '0 : acc_ext[OutW-1:0];
      end
    end
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign product_mod_o = result_q;

endmodule

// ===== rtl/mm_step_unit.sv =====
// shared step unit: shift-in doubling mod m and conditional modular add
module mm_step_unit #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic [DATA_WIDTH-1:0] y_i,
  input  logic                  shift_bit_i,
  input  logic [DATA_WIDTH-1:0] acc_i,
  input  logic                  add_en_i,
  input  logic [DATA_WIDTH-1:0] modulus_i,
  output logic [DATA_WIDTH-1:0] dbl_o,
  output logic [DATA_WIDTH-1:0] acc_o
);

  logic [DATA_WIDTH:0] dbl_raw;
  logic [DATA_WIDTH:0] dbl_sub;
  logic [DATA_WIDTH:0] sum_raw;
  logic [DATA_WIDTH:0] sum_sub;
  logic [DATA_WIDTH:0] mod_ext;

  assign mod_ext = {1'b0, modulus_i};

  // doubling with a shifted-in bit, one conditional subtract (operand below m)
  assign dbl_raw = {y_i, shift_bit_i};
  assign dbl_sub = dbl_raw - mod_ext;
  assign dbl_o   = (dbl_raw >= mod_ext) ? dbl_sub[DATA_WIDTH-1:0] : dbl_raw[DATA_WIDTH-1:0];

  // modular add of both operands below m, wraps when the sum reaches m
  assign sum_raw = {1'b0, acc_i} + {1'b0, y_i};
  assign sum_sub = sum_raw - mod_ext;
  always_comb begin
    if (!add_en_i) begin
      acc_o = acc_i;
    end else if (sum_raw >= mod_ext) begin
      acc_o = sum_sub[DATA_WIDTH-1:0];
    end else begin
      acc_o = sum_raw[DATA_WIDTH-1:0];
    end
  end

endmodule

// ===== rtl/mm_checker.sv =====
// port-level checker for the modular multiplier, bound to the top level
module mm_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start_i,
  input logic                         busy_o,
  input logic                         done_o,
  input logic [mm_pkg::OUT_WIDTH-1:0] product_mod_o
);

  // an accepted transaction makes the block busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("busy not raised after accepted transaction");

  // the result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // a result appears only once the work is finished
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // every finished transaction delivers a result
  a_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("transaction finished without a result");

  // a result shown for one cycle does not glitch to unknown
  a_result_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !$isunknown(product_mod_o))
    else $error("result unknown while strobed");

endmodule

bind modular_multiplier mm_checker u_mm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .done_o        (done_o),
  .product_mod_o (product_mod_o)
);

// ===== bench/tb_top.sv =====
// self-checking testbench for the shift-and-add modular multiplier
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned DATA_WIDTH  = 32;
  localparam int unsigned RESULT_WAIT = 2 * DATA_WIDTH + 8;
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned RANDOM_ITEMS = 1300;

  // one directed row; the expected residue is typed in only where obvious
  typedef struct {
    logic [mm_pkg::IN_WIDTH-1:0]  mplier;
    logic [mm_pkg::IN_WIDTH-1:0]  mcand;
    logic [mm_pkg::IN_WIDTH-1:0]  modulus;
    bit                           typed;
    logic [mm_pkg::OUT_WIDTH-1:0] residue;
  } stim_row_t;

  // one pending result with the number of the transaction that caused it
  typedef struct {
    int unsigned                  tag;
    logic [mm_pkg::OUT_WIDTH-1:0] residue;
  } pending_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         start_i;
  logic                         busy_o;
  logic [mm_pkg::IN_WIDTH-1:0]  multiplier_i;
  logic [mm_pkg::IN_WIDTH-1:0]  multiplicand_i;
  logic [mm_pkg::IN_WIDTH-1:0]  modulus_i;
  logic                         done_o;
  logic [mm_pkg::OUT_WIDTH-1:0] product_mod_o;

  stim_row_t   directed_rows[$];
  pending_t    pending_residues[$];
  int unsigned sent_count;
  int unsigned error_count;

  modular_multiplier #(
    .DATA_WIDTH(DATA_WIDTH)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .multiplier_i  (multiplier_i),
    .multiplicand_i(multiplicand_i),
    .modulus_i     (modulus_i),
    .done_o        (done_o),
    .product_mod_o (product_mod_o)
  );

  // 50 MHz clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // (x + y) mod m for x, y below m, never wider than 64 bits
  function automatic logic [63:0] add_mod(input logic [63:0] x, input logic [63:0] y,
                                          input logic [63:0] m);
    logic [63:0] gap;
    gap = m - y;
    if (x >= gap) return x - gap;
    return x + y;
  endfunction

  // a * b mod m by scanning a from its lsb, low 31 bits kept
  function automatic logic [mm_pkg::OUT_WIDTH-1:0] residue_of_product(
      input logic [mm_pkg::IN_WIDTH-1:0] a, input logic [mm_pkg::IN_WIDTH-1:0] b,
      input logic [mm_pkg::IN_WIDTH-1:0] m);
    logic [63:0] acc;
    logic [63:0] cand;
    logic [63:0] mod64;
    acc = '0;
    if (m == '0) return '0;
    mod64 = {32'd0, m};
    cand  = {32'd0, b} % mod64;
    for (int i = 0; i < DATA_WIDTH; i++) begin
      if (a[i]) acc = add_mod(acc, cand, mod64);
      cand = add_mod(cand, cand, mod64);
    end
    return acc[mm_pkg::OUT_WIDTH-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic add_row(input logic [31:0] a, input logic [31:0] b, input logic [31:0] m,
                         input bit typed, input logic [30:0] residue);
    stim_row_t row;
    row.mplier  = a;
    row.mcand   = b;
    row.modulus = m;
    row.typed   = typed;
    row.residue = residue;
    directed_rows.push_back(row);
  endtask

  // drive one transaction and hold it until the block takes it
  task automatic send_product(input logic [31:0] a, input logic [31:0] b,
                              input logic [31:0] m, input bit typed,
                              input logic [30:0] typed_residue);
    pending_t entry;
    start_i        <= 1'b1;
    multiplier_i   <= a;
    multiplicand_i <= b;
    modulus_i      <= m;
    do @(posedge clk_i); while (!(start_i && !busy_o));
    entry.tag     = sent_count;
    entry.residue = typed ? typed_residue : residue_of_product(a, b, m);
    pending_residues.push_back(entry);
    sent_count++;
  endtask

  // random factor with a bias toward edge patterns
  function automatic logic [31:0] pick_factor();
    logic [31:0] bitpos;
    bitpos = 32'h1 << $urandom_range(31, 0);
    case ($urandom_range(15, 0))
      10:      return '0;
      11:      return '1;
      12:      return $urandom_range(255, 0);
      13:      return bitpos;
      14:      return ~bitpos;
      15:      return $urandom & $urandom;
      default: return $urandom;
    endcase
  endfunction

  // random modulus, mostly within 1..2^31, now and then any 32-bit value
  function automatic logic [31:0] pick_modulus();
    case ($urandom_range(15, 0))
      4:       return $urandom_range(16, 1);
      5:       return 32'h1 << $urandom_range(31, 0);
      6:       return 32'h8000_0000 - $urandom_range(16, 0);
      7:       return $urandom;
      8:       return $urandom_range(32'h0000_ffff, 1);
      default: return $urandom_range(32'h8000_0000, 1);
    endcase
  endfunction

  // result checker: every strobe must match the oldest pending transaction
  always @(posedge clk_i) begin
    pending_t head;
    if (rst_ni && done_o) begin
      if (pending_residues.size() == 0) begin
        report_mismatch($sformatf("result 0x%08h with no transaction pending",
                                  product_mod_o));
      end else begin
        head = pending_residues.pop_front();
        if (product_mod_o !== head.residue)
          report_mismatch($sformatf("transaction %0d product_mod got 0x%08h want 0x%08h",
                                    head.tag, product_mod_o, head.residue));
      end
    end
  end

  // watchdog on cycles where nothing moves
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (start_i && !busy_o) || done_o) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // stimulus: reset, directed table, then random bursts
  initial begin
    int unsigned remaining;
    int unsigned burst_len;
    int unsigned gap;
    stim_row_t   row;

    sent_count     = 0;
    error_count    = 0;
    rst_ni         <= 1'b0;
    start_i        <= 1'b0;
    multiplier_i   <= '0;
    multiplicand_i <= '0;
    modulus_i      <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero factors, zero modulus, modulus of one
    add_row(32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 1, 31'd0);
    add_row(32'h0000_0000, 32'hffff_ffff, 32'h7fff_ffff, 1, 31'd0);
    add_row(32'hffff_ffff, 32'h0000_0000, 32'h8000_0000, 1, 31'd0);
    add_row(32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000, 1, 31'd0);
    add_row(32'hffff_ffff, 32'hffff_ffff, 32'h0000_0001, 1, 31'd0);
    // extremes of the range
    add_row(32'h0000_0001, 32'h0000_0005, 32'h0000_0007, 1, 31'd5);
    add_row(32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000, 1, 31'd1);
    add_row(32'h0000_0001, 32'hffff_ffff, 32'h8000_0000, 1, 31'h7fff_ffff);
    add_row(32'hffff_ffff, 32'h0000_0001, 32'h7fff_ffff, 1, 31'd1);
    add_row(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1, 31'd1);
    add_row(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1, 31'd1);
    add_row(32'h0000_0001, 32'h0000_0001, 32'h0000_0002, 1, 31'd1);
    add_row(32'hffff_ffff, 32'hffff_ffff, 32'h0000_0002, 1, 31'd1);
    // modulus above 2^31, residue cut to 31 bits
    add_row(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1, 31'd0);
    add_row(32'h0000_0003, 32'h0000_000a, 32'hffff_ffff, 1, 31'd30);
    add_row(32'h0000_0002, 32'hffff_fffe, 32'hffff_ffff, 1, 31'h7fff_fffd);
    add_row(32'hffff_ffff, 32'hffff_fffe, 32'hffff_fffd, 0, '0);
    // mixed patterns left to the predictor
    add_row(32'h1234_5678, 32'h9abc_def0, 32'h7fff_ffff, 0, '0);
    add_row(32'haaaa_aaaa, 32'h5555_5555, 32'h7fff_fffe, 0, '0);
    add_row(32'h5555_5555, 32'haaaa_aaaa, 32'h0001_2345, 0, '0);
    add_row(32'hdead_beef, 32'hcafe_babe, 32'h7fff_ffff, 0, '0);
    add_row(32'h8000_0001, 32'hffff_ffff, 32'h4000_0001, 0, '0);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_product(row.mplier, row.mcand, row.modulus, row.typed, row.residue);
      if (i % 3 == 1) begin
        start_i <= 1'b0;
        repeat ($urandom_range(40, 1)) @(posedge clk_i);
      end
    end

    // random bursts, gaps spread across the busy window
    remaining = RANDOM_ITEMS;
    while (remaining > 0) begin
      burst_len = ($urandom_range(3, 0) == 0) ? 16 : $urandom_range(6, 1);
      for (int k = 0; k < burst_len && remaining > 0; k++) begin
        send_product(pick_factor(), pick_factor(), pick_modulus(), 0, '0);
        remaining--;
      end
      case ($urandom_range(3, 0))
        0:       gap = 0;
        1, 2:    gap = $urandom_range(5, 1);
        default: gap = $urandom_range(80, 6);
      endcase
      if (gap > 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end

    // drain and let any stray strobe show up
    start_i <= 1'b0;
    while (pending_residues.size() != 0) @(posedge clk_i);
    repeat (RESULT_WAIT) @(posedge clk_i);

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== modular_multiplier.f =====
rtl/mm_pkg.sv
rtl/mm_step_unit.sv
rtl/modular_multiplier.sv
rtl/mm_checker.sv
bench/tb_top.sv
